// ===== rtl/stt_pkg.sv =====
package stt_pkg;

	localparam int LINE_BITS = 16;
	localparam int KIND_BITS = 5;
	localparam int KW_BITS   = 4;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_EQ     = 2'd3
	} mode_t;

	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [KW_BITS-1:0]   kw_t;

	localparam kind_t KIND_IDENT  = 5'd0;
	localparam kind_t KIND_IF     = 5'd1;
	localparam kind_t KIND_WHILE  = 5'd2;
	localparam kind_t KIND_VAR    = 5'd3;
	localparam kind_t KIND_NUMBER = 5'd4;
	localparam kind_t KIND_EOF    = 5'd5;
	localparam kind_t KIND_LBRACE = 5'd6;
	localparam kind_t KIND_RBRACE = 5'd7;
	localparam kind_t KIND_LPAREN = 5'd8;
	localparam kind_t KIND_RPAREN = 5'd9;
	localparam kind_t KIND_LBRACK = 5'd10;
	localparam kind_t KIND_RBRACK = 5'd11;
	localparam kind_t KIND_GT     = 5'd12;
	localparam kind_t KIND_LT     = 5'd13;
	localparam kind_t KIND_PLUS   = 5'd14;
	localparam kind_t KIND_MINUS  = 5'd15;
	localparam kind_t KIND_STAR   = 5'd16;
	localparam kind_t KIND_SLASH  = 5'd17;
	localparam kind_t KIND_ASSIGN = 5'd18;
	localparam kind_t KIND_EQ     = 5'd19;
	localparam kind_t KIND_SEMI   = 5'd20;
	localparam kind_t KIND_COLON  = 5'd21;
	localparam kind_t KIND_ERROR  = 5'd22;

	// keyword prefix tracker codes
	localparam kw_t KW_NONE  = 4'd0;
	localparam kw_t KW_I     = 4'd1;
	localparam kw_t KW_IF    = 4'd2;
	localparam kw_t KW_W     = 4'd3;
	localparam kw_t KW_WH    = 4'd4;
	localparam kw_t KW_WHI   = 4'd5;
	localparam kw_t KW_WHIL  = 4'd6;
	localparam kw_t KW_WHILE = 4'd7;
	localparam kw_t KW_V     = 4'd8;
	localparam kw_t KW_VA    = 4'd9;
	localparam kw_t KW_VAR   = 4'd10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_US    = 8'h5F;

endpackage

// ===== rtl/stt_scan.sv =====
module stt_scan #(
	parameter int OFFSET_BITS = 16,
	parameter int LENGTH_MAX  = 255,
	parameter int LEN_BITS    = 8,
	parameter int TOK_BITS    = 46
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          character,
	output logic [1:0]          emit_cnt,
	output logic [TOK_BITS-1:0] tok0,
	output logic [TOK_BITS-1:0] tok1
);

	localparam logic [LEN_BITS-1:0] LenSat = LEN_BITS'(LENGTH_MAX);
	localparam logic [LEN_BITS-1:0] LenOne = LEN_BITS'(1);
	localparam logic [LEN_BITS-1:0] LenTwo = LEN_BITS'(2);

	stt_pkg::mode_t                mode_q, mode_d;
	stt_pkg::kw_t                  kw_q, kw_d;
	logic [LEN_BITS-1:0]           run_len_q, run_len_d;
	logic [OFFSET_BITS-1:0]        run_start_q, run_start_d;
	logic [OFFSET_BITS-1:0]        off_q;
	logic [stt_pkg::LINE_BITS-1:0] line_q, line_d;

	logic is_ws, is_alpha, is_digit, is_dot, is_us, is_eq, is_nul;

	logic                fr_emit, fr_run, fr_nl;
	stt_pkg::kind_t      fr_kind;
	logic [LEN_BITS-1:0] fr_len;
	stt_pkg::mode_t      fr_mode;
	stt_pkg::kw_t        fr_kw;

	logic                end_emit, use_fresh, fresh_emit;
	stt_pkg::kind_t      end_kind;
	logic [LEN_BITS-1:0] end_len, run_len_inc;

	function automatic stt_pkg::kw_t kw_first(input logic [7:0] c);
		stt_pkg::kw_t r;
		case (c)
			"i":     r = stt_pkg::KW_I;
			"w":     r = stt_pkg::KW_W;
			"v":     r = stt_pkg::KW_V;
			default: r = stt_pkg::KW_NONE;
		endcase
		return r;
	endfunction

	function automatic stt_pkg::kw_t kw_next(input stt_pkg::kw_t p, input logic [7:0] c);
		stt_pkg::kw_t r;
		r = stt_pkg::KW_NONE;
		case (p)
			stt_pkg::KW_I:    if (c == "f") r = stt_pkg::KW_IF;
			stt_pkg::KW_W:    if (c == "h") r = stt_pkg::KW_WH;
			stt_pkg::KW_WH:   if (c == "i") r = stt_pkg::KW_WHI;
			stt_pkg::KW_WHI:  if (c == "l") r = stt_pkg::KW_WHIL;
			stt_pkg::KW_WHIL: if (c == "e") r = stt_pkg::KW_WHILE;
			stt_pkg::KW_V:    if (c == "a") r = stt_pkg::KW_VA;
			stt_pkg::KW_VA:   if (c == "r") r = stt_pkg::KW_VAR;
			default:          r = stt_pkg::KW_NONE;
		endcase
		return r;
	endfunction

	function automatic stt_pkg::kind_t symbol_kind(input logic [7:0] c);
		stt_pkg::kind_t r;
		case (c)
			"{":     r = stt_pkg::KIND_LBRACE;
			"}":     r = stt_pkg::KIND_RBRACE;
			"(":     r = stt_pkg::KIND_LPAREN;
			")":     r = stt_pkg::KIND_RPAREN;
			"[":     r = stt_pkg::KIND_LBRACK;
			"]":     r = stt_pkg::KIND_RBRACK;
			">":     r = stt_pkg::KIND_GT;
			"<":     r = stt_pkg::KIND_LT;
			"+":     r = stt_pkg::KIND_PLUS;
			"-":     r = stt_pkg::KIND_MINUS;
			"*":     r = stt_pkg::KIND_STAR;
			"/":     r = stt_pkg::KIND_SLASH;
			";":     r = stt_pkg::KIND_SEMI;
			":":     r = stt_pkg::KIND_COLON;
			default: r = stt_pkg::KIND_ERROR;
		endcase
		return r;
	endfunction

	function automatic stt_pkg::kind_t ident_kind(input stt_pkg::kw_t p);
		stt_pkg::kind_t r;
		case (p)
			stt_pkg::KW_IF:    r = stt_pkg::KIND_IF;
			stt_pkg::KW_WHILE: r = stt_pkg::KIND_WHILE;
			stt_pkg::KW_VAR:   r = stt_pkg::KIND_VAR;
			default:           r = stt_pkg::KIND_IDENT;
		endcase
		return r;
	endfunction

	assign is_ws    = (character == stt_pkg::CH_SPACE) || (character == stt_pkg::CH_TAB) ||
	                  (character == stt_pkg::CH_NL);
	assign is_alpha = ((character >= "a") && (character <= "z")) ||
	                  ((character >= "A") && (character <= "Z"));
	assign is_digit = (character >= "0") && (character <= "9");
	assign is_dot   = character == stt_pkg::CH_DOT;
	assign is_us    = character == stt_pkg::CH_US;
	assign is_eq    = character == stt_pkg::CH_EQ;
	assign is_nul   = character == stt_pkg::CH_NUL;

	assign run_len_inc = (run_len_q >= LenSat) ? LenSat : run_len_q + LenOne;

	// what the character does when no token is pending
	always_comb begin
		fr_emit = 1'b0;
		fr_run  = 1'b0;
		fr_nl   = 1'b0;
		fr_kind = stt_pkg::KIND_ERROR;
		fr_len  = LenOne;
		fr_mode = stt_pkg::MODE_IDLE;
		fr_kw   = stt_pkg::KW_NONE;
		if (is_ws) begin
			fr_nl = character == stt_pkg::CH_NL;
		end else if (is_alpha) begin
			fr_run  = 1'b1;
			fr_mode = stt_pkg::MODE_IDENT;
			fr_kw   = kw_first(character);
		end else if (is_digit || is_dot) begin
			fr_run  = 1'b1;
			fr_mode = stt_pkg::MODE_NUMBER;
		end else if (is_eq) begin
			fr_run  = 1'b1;
			fr_mode = stt_pkg::MODE_EQ;
		end else if (is_nul) begin
			fr_emit = 1'b1;
			fr_kind = stt_pkg::KIND_EOF;
			fr_len  = '0;
		end else begin
			fr_emit = 1'b1;
			fr_kind = symbol_kind(character);
		end
	end

	always_comb begin
		end_emit    = 1'b0;
		end_kind    = stt_pkg::KIND_IDENT;
		end_len     = run_len_q;
		use_fresh   = 1'b0;
		mode_d      = mode_q;
		kw_d        = kw_q;
		run_len_d   = run_len_q;
		run_start_d = run_start_q;
		line_d      = line_q;
		case (mode_q)
			stt_pkg::MODE_IDENT: begin
				if (is_alpha || is_digit || is_us) begin
					run_len_d = run_len_inc;
					kw_d      = kw_next(kw_q, character);
				end else begin
					end_emit  = 1'b1;
					end_kind  = ident_kind(kw_q);
					use_fresh = 1'b1;
				end
			end
			stt_pkg::MODE_NUMBER: begin
				if (is_digit || is_dot) begin
					run_len_d = run_len_inc;
				end else begin
					end_emit  = 1'b1;
					end_kind  = stt_pkg::KIND_NUMBER;
					use_fresh = 1'b1;
				end
			end
			stt_pkg::MODE_EQ: begin
				end_emit = 1'b1;
				if (is_eq) begin
					end_kind  = stt_pkg::KIND_EQ;
					end_len   = LenTwo;
					mode_d    = stt_pkg::MODE_IDLE;
					kw_d      = stt_pkg::KW_NONE;
					run_len_d = '0;
				end else begin
					end_kind  = stt_pkg::KIND_ASSIGN;
					end_len   = LenOne;
					use_fresh = 1'b1;
				end
			end
			default: begin
				use_fresh = 1'b1;
			end
		endcase
		if (use_fresh) begin
			mode_d    = fr_mode;
			kw_d      = fr_kw;
			run_len_d = fr_run ? LenOne : '0;
			if (fr_run) begin
				run_start_d = off_q;
			end
			if (fr_nl && (line_q != '1)) begin
				line_d = line_q + 1'b1;
			end
		end
	end

	assign fresh_emit = use_fresh && fr_emit;
	assign emit_cnt   = {end_emit && fresh_emit, end_emit ^ fresh_emit};

	// every token of one character carries the line count from before it
	assign tok1 = {fr_kind, off_q, fr_len, line_q, 1'b1};
	assign tok0 = end_emit ? {end_kind, run_start_q, end_len, line_q, !fresh_emit} : tok1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= stt_pkg::MODE_IDLE;
			kw_q        <= stt_pkg::KW_NONE;
			run_len_q   <= '0;
			run_start_q <= '0;
			off_q       <= '0;
			line_q      <= '0;
		end else if (take) begin
			mode_q      <= mode_d;
			kw_q        <= kw_d;
			run_len_q   <= run_len_d;
			run_start_q <= run_start_d;
			off_q       <= off_q + 1'b1;
			line_q      <= line_d;
		end
	end

	a_eq_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == stt_pkg::MODE_EQ) |-> (run_len_q == LenOne))
		else $error("pending '=' run with length other than one");

	a_line_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (line_q >= $past(line_q)))
		else $error("line count went backwards");

	a_idle_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == stt_pkg::MODE_IDLE) |-> (run_len_q == '0))
		else $error("idle with a nonzero run length");

endmodule

// ===== rtl/stt_fifo.sv =====
module stt_fifo #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  logic [WIDTH-1:0] push0,
	input  logic [WIDTH-1:0] push1,
	input  logic             pop,
	output logic             room2,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	localparam int PtrBits = $clog2(DEPTH);
	localparam int CntBits = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]   mem [DEPTH];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CntBits-1:0] cnt_q;
	logic               pop_ok;

	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign pop_ok    = pop && not_empty;
	assign not_empty = cnt_q != '0;
	assign room2     = cnt_q <= CntBits'(DEPTH - 2);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_ptr_nx] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrBits'(push_cnt);
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CntBits'(push_cnt) - CntBits'(pop_ok);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntBits'(DEPTH))
		else $error("token queue overflow");

	a_push_two: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2 && !pop_ok) |=> (cnt_q == $past(cnt_q) + CntBits'(2)))
		else $error("double push lost an entry");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room2)
		else $error("push into queue without room");

endmodule

// ===== rtl/source_text_tokenizer_unit.sv =====
// a token is written into the token queue when the character that causes it is taken
// throughput: one character per cycle; a character that yields two tokens takes two queue
// entries, and the 4-entry token queue accepts characters while it has two free slots
// reset: arst_n clears scan mode, offsets, line count and the token queue at once
module source_text_tokenizer_unit #(
	parameter int OFFSET_BITS = 16,
	parameter int LENGTH_MAX  = 255,
	localparam int LenBits    = $clog2(LENGTH_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  logic [7:0]                    character,
	output logic                          tok_valid,
	input  logic                          tok_ready,
	output logic [stt_pkg::KIND_BITS-1:0] token_kind,
	output logic [OFFSET_BITS-1:0]        token_start,
	output logic [LenBits-1:0]            token_length,
	output logic [stt_pkg::LINE_BITS-1:0] line_number,
	output logic                          last
);

	localparam int TokBits  = stt_pkg::KIND_BITS + OFFSET_BITS + LenBits + stt_pkg::LINE_BITS + 1;
	localparam int LineLo   = 1;
	localparam int LenLo    = LineLo + stt_pkg::LINE_BITS;
	localparam int StartLo  = LenLo + LenBits;
	localparam int KindLo   = StartLo + OFFSET_BITS;

	logic               take;
	logic [1:0]         emit_cnt, push_cnt;
	logic [TokBits-1:0] tok0, tok1, head;

	assign take     = src_valid && src_ready;
	assign push_cnt = take ? emit_cnt : 2'd0;

	stt_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_MAX (LENGTH_MAX),
		.LEN_BITS   (LenBits),
		.TOK_BITS   (TokBits)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.character(character),
		.emit_cnt (emit_cnt),
		.tok0     (tok0),
		.tok1     (tok1)
	);

	stt_fifo #(
		.WIDTH(TokBits),
		.DEPTH(4)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (tok0),
		.push1    (tok1),
		.pop      (tok_ready),
		.room2    (src_ready),
		.not_empty(tok_valid),
		.head     (head)
	);

	assign token_kind   = head[KindLo +: stt_pkg::KIND_BITS];
	assign token_start  = head[StartLo +: OFFSET_BITS];
	assign token_length = head[LenLo +: LenBits];
	assign line_number  = head[LineLo +: stt_pkg::LINE_BITS];
	assign last         = head[0];

endmodule

// ===== verif/tb.sv =====
module tb;
	import stt_pkg::*;

	localparam logic [7:0]  LEN_SAT  = 8'd255;
	localparam logic [15:0] LINE_SAT = 16'hFFFF;

	typedef struct {
		kind_t       kind;
		logic [15:0] start;
		logic [7:0]  length;
		logic [15:0] line;
		logic        last;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        src_valid;
	logic        src_ready;
	logic [7:0]  character;
	logic        tok_valid;
	logic        tok_ready;
	kind_t       token_kind;
	logic [15:0] token_start;
	logic [7:0]  token_length;
	logic [15:0] line_number;
	logic        last;

	// predictor state
	mode_t       scan_mode;
	kw_t         kw_state;
	logic [7:0]  run_len;
	logic [15:0] run_start;
	logic [15:0] char_pos;
	logic [15:0] line_cnt;
	token_t      pending_tokens[$];

	int src_idle_pct;
	int sink_idle_pct;
	int chars_sent;
	int tokens_checked;
	int error_count;

	string word_pool [0:11] = '{"if", "while", "var", "i", "wh", "whil", "va", "iff",
		"whiles", "vars", "w", "v"};
	string sym_chars = "{}()[]><+-*/;:";

	source_text_tokenizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.character    (character),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.line_number  (line_number),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic kw_t kw_start(logic [7:0] c);
		if (c == "i") return KW_I;
		if (c == "w") return KW_W;
		if (c == "v") return KW_V;
		return KW_NONE;
	endfunction

	function automatic kw_t kw_advance(kw_t p, logic [7:0] c);
		case (p)
			KW_I:    return (c == "f") ? KW_IF : KW_NONE;
			KW_W:    return (c == "h") ? KW_WH : KW_NONE;
			KW_WH:   return (c == "i") ? KW_WHI : KW_NONE;
			KW_WHI:  return (c == "l") ? KW_WHIL : KW_NONE;
			KW_WHIL: return (c == "e") ? KW_WHILE : KW_NONE;
			KW_V:    return (c == "a") ? KW_VA : KW_NONE;
			KW_VA:   return (c == "r") ? KW_VAR : KW_NONE;
			default: return KW_NONE;
		endcase
	endfunction

	function automatic kind_t symbol_of(logic [7:0] c);
		case (c)
			"{":     return KIND_LBRACE;
			"}":     return KIND_RBRACE;
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			"[":     return KIND_LBRACK;
			"]":     return KIND_RBRACK;
			">":     return KIND_GT;
			"<":     return KIND_LT;
			"+":     return KIND_PLUS;
			"-":     return KIND_MINUS;
			"*":     return KIND_STAR;
			"/":     return KIND_SLASH;
			";":     return KIND_SEMI;
			":":     return KIND_COLON;
			default: return KIND_ERROR;
		endcase
	endfunction

	function automatic kind_t word_kind(kw_t p);
		if (p == KW_IF) return KIND_IF;
		if (p == KW_WHILE) return KIND_WHILE;
		if (p == KW_VAR) return KIND_VAR;
		return KIND_IDENT;
	endfunction

	task automatic push_token(kind_t k, logic [15:0] s, logic [7:0] len);
		token_t t;
		t.kind = k;
		t.start = s;
		t.length = len;
		t.line = line_cnt;
		t.last = 1'b0;
		pending_tokens.insert(pending_tokens.size(), t);
	endtask

	task automatic close_run();
		scan_mode = MODE_IDLE;
		kw_state = KW_NONE;
		run_len = 8'd0;
	endtask

	// character seen with no token pending
	task automatic begin_char(logic [7:0] c);
		if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
			if (c == CH_NL && line_cnt != LINE_SAT)
				line_cnt++;
		end else if (is_letter(c)) begin
			scan_mode = MODE_IDENT;
			run_start = char_pos;
			run_len = 8'd1;
			kw_state = kw_start(c);
		end else if (is_numeral(c) || c == CH_DOT) begin
			scan_mode = MODE_NUMBER;
			run_start = char_pos;
			run_len = 8'd1;
			kw_state = KW_NONE;
		end else if (c == CH_EQ) begin
			scan_mode = MODE_EQ;
			run_start = char_pos;
			run_len = 8'd1;
			kw_state = KW_NONE;
		end else if (c == CH_NUL) begin
			push_token(KIND_EOF, char_pos, 8'd0);
		end else begin
			push_token(symbol_of(c), char_pos, 8'd1);
		end
	endtask

	task automatic predict_tokens(logic [7:0] c);
		int count_in;
		int tail;
		token_t t;
		count_in = pending_tokens.size();
		case (scan_mode)
			MODE_IDENT: begin
				if (is_letter(c) || is_numeral(c) || c == CH_US) begin
					if (run_len != LEN_SAT)
						run_len++;
					kw_state = kw_advance(kw_state, c);
				end else begin
					push_token(word_kind(kw_state), run_start, run_len);
					close_run();
					begin_char(c);
				end
			end
			MODE_NUMBER: begin
				if (is_numeral(c) || c == CH_DOT) begin
					if (run_len != LEN_SAT)
						run_len++;
				end else begin
					push_token(KIND_NUMBER, run_start, run_len);
					close_run();
					begin_char(c);
				end
			end
			MODE_EQ: begin
				if (c == CH_EQ) begin
					push_token(KIND_EQ, run_start, 8'd2);
					close_run();
				end else begin
					push_token(KIND_ASSIGN, run_start, 8'd1);
					close_run();
					begin_char(c);
				end
			end
			default: begin_char(c);
		endcase
		if (pending_tokens.size() > count_in) begin
			tail = pending_tokens.size() - 1;
			t = pending_tokens[tail];
			t.last = 1'b1;
			pending_tokens[tail] = t;
		end
		char_pos++;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// sender: optional idle cycles, then hold the item until it is taken
	task automatic send_char(logic [7:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			character <= 8'($urandom_range(255));
			@(posedge clk);
		end
		src_valid <= 1'b1;
		character <= c;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		predict_tokens(c);
		chars_sent++;
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic pause_until_drained();
		src_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'($urandom_range(25));
		return c + ($urandom_range(1) ? "A" : "a");
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(9);
		if (r < 6) return rand_letter();
		if (r < 9) return 8'("0" + $urandom_range(9));
		return CH_US;
	endfunction

	task automatic send_random_phrase();
		int r;
		int len;
		r = $urandom_range(99);
		if (r < 15) begin
			send_string(word_pool[$urandom_range(11)]);
		end else if (r < 32) begin
			send_char(rand_letter());
			len = $urandom_range(9);
			repeat (len) send_char(rand_word_char());
		end else if (r < 50) begin
			len = $urandom_range(1, 8);
			repeat (len)
				send_char(($urandom_range(3) == 0) ? CH_DOT : 8'("0" + $urandom_range(9)));
		end else if (r < 64) begin
			send_char(sym_chars[$urandom_range(13)]);
		end else if (r < 72) begin
			repeat ($urandom_range(1, 3)) send_char(CH_EQ);
		end else if (r < 77) begin
			send_char(CH_NUL);
		end else if (r < 85) begin
			send_char(8'($urandom_range(255)));
		end
		// otherwise tokens run into each other with no separator
		if ($urandom_range(99) < 65) begin
			case ($urandom_range(2))
				0: send_char(CH_SPACE);
				1: send_char(CH_TAB);
				default: send_char(CH_NL);
			endcase
		end
	endtask

	task automatic test_keywords_and_operators();
		send_string("if(while)var=x==9.5;");
	endtask

	task automatic test_symbols();
		send_string("{}[]<>+-*/:");
	endtask

	task automatic test_eof_and_errors();
		// pending identifier flushed ahead of end of file
		send_char("a");
		send_char(CH_NUL);
		send_char(8'hFF);
		send_char(8'h80);
		send_char(CH_TAB);
		send_char(CH_NL);
		send_char(CH_SPACE);
	endtask

	task automatic test_long_tokens();
		send_char("q");
		repeat (256) send_char(rand_word_char());
		send_char(";");
		repeat (257)
			send_char(($urandom_range(4) == 0) ? CH_DOT : 8'("0" + $urandom_range(9)));
		send_char(CH_NL);
	endtask

	task automatic test_random_traffic(int src_pct, int sink_pct, int count);
		int target;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		target = chars_sent + count;
		while (chars_sent < target)
			send_random_phrase();
	endtask

	always @(posedge clk)
		tok_ready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : check_tokens
		token_t want;
		if (arst_n && tok_valid && tok_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("unexpected token kind", int'(token_kind), -1);
			end else begin
				want = pending_tokens.pop_front();
				tokens_checked++;
				if (token_kind !== want.kind)
					report_mismatch("token_kind", int'(token_kind), int'(want.kind));
				if (token_start !== want.start)
					report_mismatch("token_start", int'(token_start), int'(want.start));
				if (token_length !== want.length)
					report_mismatch("token_length", int'(token_length), int'(want.length));
				if (line_number !== want.line)
					report_mismatch("line_number", int'(line_number), int'(want.line));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
			end
		end
	end

	initial begin
		#5000000;
		$display("timeout with %0d tokens outstanding", pending_tokens.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		character = 8'd0;
		tok_ready = 1'b0;
		scan_mode = MODE_IDLE;
		kw_state = KW_NONE;
		run_len = 8'd0;
		run_start = 16'd0;
		char_pos = 16'd0;
		line_cnt = 16'd0;
		src_idle_pct = 31;
		sink_idle_pct = 81;
		chars_sent = 0;
		tokens_checked = 0;
		error_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_keywords_and_operators();
		test_symbols();
		test_eof_and_errors();
		test_long_tokens();
		test_random_traffic(31, 81, 200);
		pause_until_drained();
		test_random_traffic(81, 31, 200);
		test_random_traffic(0, 0, 200);

		pause_until_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d characters and checked %0d tokens", chars_sent, tokens_checked);
		$display("keywords, operators, eof, bad bytes, saturated lengths, mixed stalls");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
